// ===== hdl/uart_8250_register_model_macros.svh =====
// assertion macros shared by the uart register model checker
`ifndef UART_8250_REGISTER_MODEL_MACROS_SVH
`define UART_8250_REGISTER_MODEL_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define U8250_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8250 check failed in the same cycle");

// consequent must hold in the cycle after the antecedent
`define U8250_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8250 check failed one cycle later");

`endif

// ===== hdl/u8250_pkg.sv =====
// types and constants of the 8250-style uart register model
`default_nettype none
package u8250_pkg;

    // item commands
    typedef enum logic [2:0] {
        CMD_READ    = 3'd0,
        CMD_WRITE   = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_RECEIVE = 3'd3,
        CMD_IACK    = 3'd4
    } cmd_t;

    // register offsets
    localparam logic [2:0] ADDR_RBR = 3'd0;
    localparam logic [2:0] ADDR_IER = 3'd1;
    localparam logic [2:0] ADDR_IIR = 3'd2;
    localparam logic [2:0] ADDR_LCR = 3'd3;
    localparam logic [2:0] ADDR_MCR = 3'd4;
    localparam logic [2:0] ADDR_LSR = 3'd5;
    localparam logic [2:0] ADDR_MSR = 3'd6;
    localparam logic [2:0] ADDR_SCR = 3'd7;

    // reset values
    localparam logic [7:0] IIR_RESET = 8'h01;
    localparam logic [7:0] LSR_RESET = 8'h60;

    // bit positions
    localparam int LCR_DLAB_BIT = 7;
    localparam int MCR_LOOP_BIT = 4;
    localparam int LSR_DR_BIT   = 0;
    localparam int LSR_THRE_BIT = 5;
    localparam int IIR_NOINT_BIT = 0;

    // interrupt identification codes (bits 3:1)
    localparam logic [2:0] IID_RX    = 3'd2;
    localparam logic [2:0] IID_THRE  = 3'd1;
    localparam logic [2:0] IID_MODEM = 3'd0;

    // one input word
    typedef struct packed {
        logic [2:0] command;
        logic [2:0] address;
        logic [7:0] write_data;
        logic       dcd_line;
        logic       ri_line;
        logic       dsr_line;
        logic       cts_line;
    } item_t;

    // one result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       modem_lines_valid;
        logic [3:0] modem_lines;
        logic       irq_pending;
        logic       rx_accepted;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/u8250_in_stage.sv =====
// input register stage holding one accepted word
`default_nettype none
module u8250_in_stage
    import u8250_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire item_t item_in,
    input  wire logic  ready,
    output item_t      item,
    output logic       fire
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // handshake and hand-off to the result stage
    assign in_stall = valid_reg && !ready;
    assign accept   = in_valid && !in_stall;
    assign fire     = valid_reg && ready;
    assign item     = item_reg;

    // occupancy of the stage
    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_in;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/u8250_regfile.sv =====
// uart register file: state registers and the per-word update logic
`default_nettype none
module u8250_regfile
    import u8250_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire item_t item,
    input  wire logic  fire,
    output result_t    result
);

    logic [7:0] rbr_reg, rbr_next;
    logic [3:0] ier_reg, ier_next;
    logic [7:0] iir_reg, iir_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [4:0] mcr_reg, mcr_next;
    logic [7:0] lsr_reg, lsr_next;
    logic [7:0] msr_reg, msr_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;

    logic       dlab;
    logic [3:0] msr_lines;
    logic [7:0] msr_sample;
    logic [7:0] iir_scan;
    cmd_t       cmd;

    assign dlab = lcr_reg[LCR_DLAB_BIT];
    assign cmd  = cmd_t'(item.command);

    // modem status sample with delta bits against the last value
    assign msr_lines  = {item.dcd_line, item.ri_line, item.dsr_line, item.cts_line};
    assign msr_sample = {msr_lines, msr_lines ^ msr_reg[7:4]};

    // fixed-priority interrupt scan
    always_comb
    begin
        iir_scan = iir_reg;
        if (ier_reg == 4'd0)
        begin
            iir_scan[IIR_NOINT_BIT] = 1'b1;
        end
        else if (iir_reg[IIR_NOINT_BIT])
        begin
            priority if (ier_reg[0] && lsr_reg[LSR_DR_BIT])
            begin
                iir_scan = {iir_reg[7:4], IID_RX, 1'b0};
            end
            else if (ier_reg[1] && lsr_reg[LSR_THRE_BIT])
            begin
                iir_scan = {iir_reg[7:4], IID_THRE, 1'b0};
            end
            else if (ier_reg[3] && (msr_reg[3:0] != 4'd0))
            begin
                iir_scan = {iir_reg[7:4], IID_MODEM, 1'b0};
            end
            else
            begin
                // no enabled source active
                iir_scan = iir_reg;
            end
        end
        // pending interrupt clears bits 5:4
        if (!iir_scan[IIR_NOINT_BIT])
        begin
            iir_scan[5:4] = 2'b00;
        end
    end

    // next state and result for the word in the input stage
    always_comb
    begin
        rbr_next = rbr_reg;
        ier_next = ier_reg;
        iir_next = iir_reg;
        fcr_next = fcr_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        msr_next = msr_reg;
        scr_next = scr_reg;
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        result   = '0;

        unique case (cmd)
            CMD_READ:
            begin
                unique case (item.address)
                    ADDR_RBR:
                    begin
                        if (dlab)
                        begin
                            result.read_data = dll_reg;
                        end
                        else
                        begin
                            result.read_data     = rbr_reg;
                            lsr_next[LSR_DR_BIT] = 1'b0;
                        end
                    end
                    ADDR_IER: result.read_data = dlab ? dlm_reg : {4'd0, ier_reg};
                    ADDR_IIR: result.read_data = iir_reg;
                    ADDR_LCR: result.read_data = lcr_reg;
                    ADDR_MCR: result.read_data = {3'd0, mcr_reg};
                    ADDR_LSR: result.read_data = lsr_reg;
                    ADDR_MSR:
                    begin
                        msr_next         = msr_sample;
                        result.read_data = msr_sample;
                    end
                    ADDR_SCR: result.read_data = scr_reg;
                endcase
            end
            CMD_WRITE:
            begin
                unique case (item.address)
                    ADDR_RBR:
                    begin
                        if (dlab)
                        begin
                            dll_next = item.write_data;
                        end
                        else
                        begin
                            // loopback fills the receive buffer when empty
                            if (mcr_reg[MCR_LOOP_BIT] && !lsr_reg[LSR_DR_BIT])
                            begin
                                rbr_next             = item.write_data;
                                lsr_next[LSR_DR_BIT] = 1'b1;
                            end
                            result.tx_valid = 1'b1;
                            result.tx_byte  = item.write_data;
                        end
                    end
                    ADDR_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = item.write_data;
                        end
                        else
                        begin
                            ier_next = item.write_data[3:0];
                        end
                    end
                    ADDR_IIR: fcr_next = item.write_data;
                    ADDR_LCR: lcr_next = item.write_data;
                    ADDR_MCR:
                    begin
                        result.modem_lines_valid = 1'b1;
                        result.modem_lines       = item.write_data[3:0];
                        mcr_next                 = item.write_data[4:0];
                    end
                    ADDR_LSR: lsr_next = item.write_data;
                    ADDR_MSR: msr_next = item.write_data;
                    ADDR_SCR: scr_next = item.write_data;
                endcase
            end
            CMD_TICK:
            begin
                iir_next = iir_scan;
            end
            CMD_RECEIVE:
            begin
                if (!lsr_reg[LSR_DR_BIT])
                begin
                    rbr_next             = item.write_data;
                    lsr_next[LSR_DR_BIT] = 1'b1;
                    result.rx_accepted   = 1'b1;
                end
            end
            CMD_IACK:
            begin
                iir_next[IIR_NOINT_BIT] = 1'b1;
            end
            default:
            begin
                iir_next = iir_reg;
            end
        endcase

        result.irq_pending = !iir_next[IIR_NOINT_BIT];
    end

    // state update when a word passes to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rbr_reg <= '0;
            ier_reg <= '0;
            iir_reg <= IIR_RESET;
            fcr_reg <= '0;
            lcr_reg <= '0;
            mcr_reg <= '0;
            lsr_reg <= LSR_RESET;
            msr_reg <= '0;
            scr_reg <= '0;
            dll_reg <= '0;
            dlm_reg <= '0;
        end
        else if (fire)
        begin
            rbr_reg <= rbr_next;
            ier_reg <= ier_next;
            iir_reg <= iir_next;
            fcr_reg <= fcr_next;
            lcr_reg <= lcr_next;
            mcr_reg <= mcr_next;
            lsr_reg <= lsr_next;
            msr_reg <= msr_next;
            scr_reg <= scr_next;
            dll_reg <= dll_next;
            dlm_reg <= dlm_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/u8250_out_stage.sv =====
// result register stage facing the output channel
`default_nettype none
module u8250_out_stage
    import u8250_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t result_in,
    output logic         ready,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // free when empty or when the held word leaves this cycle
    assign ready     = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/uart_8250_register_model.sv =====
// top level of the 8250-style uart register model
// Each input word is a bus read, a bus write, an interrupt scan tick, a received byte
// or an interrupt acknowledge, and yields exactly one result word. A word is held in
// an input register, goes through the register-file update logic and is captured in
// a result register, so the block takes one word per clock while the output is not
// stalled; the result is presented from the result register and leaves when the output
// is not stalled. The result register lets a new word enter while a finished result
// still waits.
`default_nettype none
module uart_8250_register_model
    import u8250_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [2:0] command,
    input  wire logic [2:0] address,
    input  wire logic [7:0] write_data,
    input  wire logic       dcd_line,
    input  wire logic       ri_line,
    input  wire logic       dsr_line,
    input  wire logic       cts_line,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_data,
    output logic            tx_valid,
    output logic [7:0]      tx_byte,
    output logic            modem_lines_valid,
    output logic [3:0]      modem_lines,
    output logic            irq_pending,
    output logic            rx_accepted
);

    item_t   item_in;
    item_t   item;
    logic    fire;
    logic    ready;
    result_t result_comb;
    result_t result;

    // gather the input word
    assign item_in = '{command: command, address: address, write_data: write_data,
                       dcd_line: dcd_line, ri_line: ri_line, dsr_line: dsr_line,
                       cts_line: cts_line};

    u8250_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .item_in  (item_in),
        .ready    (ready),
        .item     (item),
        .fire     (fire)
    );

    u8250_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .fire   (fire),
        .result (result_comb)
    );

    u8250_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result_in (result_comb),
        .ready     (ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // spread the result word onto the ports
    assign read_data         = result.read_data;
    assign tx_valid          = result.tx_valid;
    assign tx_byte           = result.tx_byte;
    assign modem_lines_valid = result.modem_lines_valid;
    assign modem_lines       = result.modem_lines;
    assign irq_pending       = result.irq_pending;
    assign rx_accepted       = result.rx_accepted;

endmodule
`default_nettype wire

// ===== hdl/u8250_checker.sv =====
// port-level checks for the uart register model, bound to the top level
`default_nettype none
`include "uart_8250_register_model_macros.svh"
module u8250_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] read_data,
    input wire logic       tx_valid,
    input wire logic [7:0] tx_byte,
    input wire logic       modem_lines_valid,
    input wire logic [3:0] modem_lines,
    input wire logic       rx_accepted
);

    // a stalled result word stays put
    `U8250_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(read_data) && $stable(tx_byte))

    // no transmit byte without a transmit
    `U8250_ASSERT_NOW(a_tx_zero, out_valid && !tx_valid, tx_byte == 8'd0)

    // no modem line value without an mcr write
    `U8250_ASSERT_NOW(a_ml_zero, out_valid && !modem_lines_valid, modem_lines == 4'd0)

    // a word is at most one of a transmit, a receive or a read, never two of them
    `U8250_ASSERT_NOW(a_one_kind, out_valid && (tx_valid || rx_accepted), read_data == 8'd0 && !(tx_valid && rx_accepted))

endmodule

bind uart_8250_register_model u8250_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .read_data         (read_data),
    .tx_valid          (tx_valid),
    .tx_byte           (tx_byte),
    .modem_lines_valid (modem_lines_valid),
    .modem_lines       (modem_lines),
    .rx_accepted       (rx_accepted)
);
`default_nettype wire

// ===== test/testbench.sv =====
// testbench of the 8250-style uart register model: directed and random words, scoreboard check
module testbench
    import u8250_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // command codes with no function in the block
    localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] CMD_LAST_UNUSED  = 3'd7;

    // interrupt enable bits
    localparam int IER_RX_BIT    = 0;
    localparam int IER_THRE_BIT  = 1;
    localparam int IER_MODEM_BIT = 3;

    localparam int IDLE_PERCENT = 26;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [2:0] command = '0;
    logic [2:0] address = '0;
    logic [7:0] write_data = '0;
    logic       dcd_line = 1'b0;
    logic       ri_line = 1'b0;
    logic       dsr_line = 1'b0;
    logic       cts_line = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       modem_lines_valid;
    logic [3:0] modem_lines;
    logic       irq_pending;
    logic       rx_accepted;

    // predicted register file
    logic [7:0] rbr_q;
    logic [3:0] ier_q;
    logic [7:0] iir_q;
    logic [7:0] fcr_q;
    logic [7:0] lcr_q;
    logic [4:0] mcr_q;
    logic [7:0] lsr_q;
    logic [7:0] msr_q;
    logic [7:0] scr_q;
    logic [7:0] dll_q;
    logic [7:0] dlm_q;

    result_t pending_results[$];
    int      mismatches = 0;
    int      results_checked = 0;
    int      irq_results = 0;
    int      tx_results = 0;
    int      words_by_cmd[8];
    int      idle_cycles = 0;
    bit      quiet = 1'b0;

    uart_8250_register_model i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .address           (address),
        .write_data        (write_data),
        .dcd_line          (dcd_line),
        .ri_line           (ri_line),
        .dsr_line          (dsr_line),
        .cts_line          (cts_line),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .read_data         (read_data),
        .tx_valid          (tx_valid),
        .tx_byte           (tx_byte),
        .modem_lines_valid (modem_lines_valid),
        .modem_lines       (modem_lines),
        .irq_pending       (irq_pending),
        .rx_accepted       (rx_accepted)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predict the result of one word and update the register file copy
    function automatic result_t uart_register_step(input item_t w);
        result_t    r;
        logic       dlab;
        logic [7:0] m;
        r = '0;
        dlab = lcr_q[LCR_DLAB_BIT];
        case (w.command)
            CMD_READ:
            begin
                case (w.address)
                    ADDR_RBR:
                    begin
                        if (dlab)
                            r.read_data = dll_q;
                        else
                        begin
                            r.read_data = rbr_q;
                            lsr_q[LSR_DR_BIT] = 1'b0;
                        end
                    end
                    ADDR_IER: r.read_data = dlab ? dlm_q : {4'b0, ier_q};
                    ADDR_IIR: r.read_data = iir_q;
                    ADDR_LCR: r.read_data = lcr_q;
                    ADDR_MCR: r.read_data = {3'b0, mcr_q};
                    ADDR_LSR: r.read_data = lsr_q;
                    ADDR_MSR:
                    begin
                        // sample the lines, deltas against the previous status
                        m = {w.dcd_line, w.ri_line, w.dsr_line, w.cts_line, 4'b0};
                        m[3:0] = m[7:4] ^ msr_q[7:4];
                        msr_q = m;
                        r.read_data = m;
                    end
                    default: r.read_data = scr_q;
                endcase
            end
            CMD_WRITE:
            begin
                case (w.address)
                    ADDR_RBR:
                    begin
                        if (dlab)
                            dll_q = w.write_data;
                        else
                        begin
                            // loopback fills the receive buffer only while empty
                            if (mcr_q[MCR_LOOP_BIT] && !lsr_q[LSR_DR_BIT])
                            begin
                                rbr_q = w.write_data;
                                lsr_q[LSR_DR_BIT] = 1'b1;
                            end
                            r.tx_valid = 1'b1;
                            r.tx_byte = w.write_data;
                        end
                    end
                    ADDR_IER:
                    begin
                        if (dlab)
                            dlm_q = w.write_data;
                        else
                            ier_q = w.write_data[3:0];
                    end
                    ADDR_IIR: fcr_q = w.write_data;
                    ADDR_LCR: lcr_q = w.write_data;
                    ADDR_MCR:
                    begin
                        r.modem_lines_valid = 1'b1;
                        r.modem_lines = w.write_data[3:0];
                        mcr_q = w.write_data[4:0];
                    end
                    ADDR_LSR: lsr_q = w.write_data;
                    ADDR_MSR: msr_q = w.write_data;
                    default: scr_q = w.write_data;
                endcase
            end
            CMD_TICK:
            begin
                // fixed-priority scan, only when nothing is pending
                if (ier_q == 4'd0)
                    iir_q[IIR_NOINT_BIT] = 1'b1;
                else if (iir_q[IIR_NOINT_BIT])
                begin
                    if (ier_q[IER_RX_BIT] && lsr_q[LSR_DR_BIT])
                        iir_q = {iir_q[7:4], IID_RX, 1'b0};
                    else if (ier_q[IER_THRE_BIT] && lsr_q[LSR_THRE_BIT])
                        iir_q = {iir_q[7:4], IID_THRE, 1'b0};
                    else if (ier_q[IER_MODEM_BIT] && msr_q[3:0] != 4'd0)
                        iir_q = {iir_q[7:4], IID_MODEM, 1'b0};
                end
                if (!iir_q[IIR_NOINT_BIT])
                    iir_q[5:4] = 2'b00;
            end
            CMD_RECEIVE:
            begin
                if (!lsr_q[LSR_DR_BIT])
                begin
                    rbr_q = w.write_data;
                    lsr_q[LSR_DR_BIT] = 1'b1;
                    r.rx_accepted = 1'b1;
                end
            end
            CMD_IACK: iir_q[IIR_NOINT_BIT] = 1'b1;
            default: ;
        endcase
        r.irq_pending = !iir_q[IIR_NOINT_BIT];
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("%0t: result %0d mismatch on %s: got %h, expected %h",
                 $realtime, results_checked, field, got, want);
    endtask

    task automatic compare_field(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    // check results against predictions, then predict the accepted word
    always @(posedge clk)
    begin : scoreboard
        item_t   w;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", read_data, 8'h00);
            else
            begin
                want = pending_results.pop_front();
                compare_field("read_data", read_data, want.read_data);
                compare_field("tx_valid", 8'(tx_valid), 8'(want.tx_valid));
                compare_field("tx_byte", tx_byte, want.tx_byte);
                compare_field("modem_lines_valid", 8'(modem_lines_valid),
                              8'(want.modem_lines_valid));
                compare_field("modem_lines", 8'(modem_lines), 8'(want.modem_lines));
                compare_field("irq_pending", 8'(irq_pending), 8'(want.irq_pending));
                compare_field("rx_accepted", 8'(rx_accepted), 8'(want.rx_accepted));
                if (want.irq_pending)
                    irq_results++;
                if (want.tx_valid)
                    tx_results++;
            end
            results_checked++;
        end
        if (rst_n && in_valid && !in_stall)
        begin
            w.command = command;
            w.address = address;
            w.write_data = write_data;
            w.dcd_line = dcd_line;
            w.ri_line = ri_line;
            w.dsr_line = dsr_line;
            w.cts_line = cts_line;
            pending_results.push_back(uart_register_step(w));
            words_by_cmd[command]++;
        end
    end

    // random back-pressure on the result side
    always @(posedge clk)
    begin
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word accepted for %0d cycles", $realtime, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // send one word, with random gaps ahead of it unless quiet is set
    task automatic send_word(input logic [2:0] cmd, input logic [2:0] addr,
                             input logic [7:0] data, input logic [3:0] lines);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        address    <= addr;
        write_data <= data;
        dcd_line   <= lines[3];
        ri_line    <= lines[2];
        dsr_line   <= lines[1];
        cts_line   <= lines[0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic test_reset_values();
        send_word(CMD_READ, ADDR_IIR, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_LSR, 8'hFF, 4'h0);
        send_word(CMD_READ, ADDR_SCR, 8'h00, 4'h0);
    endtask

    task automatic test_divisor_latch();
        send_word(CMD_WRITE, ADDR_LCR, 8'h80, 4'h0);
        send_word(CMD_WRITE, ADDR_RBR, 8'hFF, 4'h0);
        send_word(CMD_WRITE, ADDR_IER, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_RBR, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_IER, 8'h00, 4'h0);
        send_word(CMD_WRITE, ADDR_LCR, 8'h7F, 4'h0);
    endtask

    // loopback loads the receive buffer, a full buffer drops bytes
    task automatic test_loopback();
        send_word(CMD_WRITE, ADDR_MCR, 8'hFF, 4'h0);
        send_word(CMD_WRITE, ADDR_RBR, 8'hFF, 4'h0);
        send_word(CMD_WRITE, ADDR_RBR, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_RBR, 8'h00, 4'h0);
        send_word(CMD_RECEIVE, ADDR_RBR, 8'h81, 4'h0);
        send_word(CMD_RECEIVE, ADDR_RBR, 8'h7E, 4'h0);
    endtask

    // interrupt scan, acknowledge, modem deltas, raw register writes and an unused command
    task automatic test_interrupts();
        send_word(CMD_WRITE, ADDR_IER, 8'hFF, 4'h0);
        send_word(CMD_TICK, ADDR_RBR, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_IIR, 8'h00, 4'h0);
        send_word(CMD_IACK, ADDR_RBR, 8'h00, 4'h0);
        send_word(CMD_READ, ADDR_MSR, 8'h00, 4'hF);
        send_word(CMD_WRITE, ADDR_IIR, 8'hFF, 4'h0);
        send_word(CMD_WRITE, ADDR_LSR, 8'h00, 4'h0);
        send_word(CMD_WRITE, ADDR_MSR, 8'hFF, 4'h0);
        send_word(CMD_LAST_UNUSED, ADDR_SCR, 8'hFF, 4'hF);
    endtask

    // random mix of bus traffic and events
    task automatic test_random_traffic(input int count, input bit no_gaps);
        int         sel;
        logic [2:0] cmd;
        quiet = no_gaps;
        repeat (count)
        begin
            sel = $urandom_range(99);
            if (sel < 30)
                cmd = CMD_READ;
            else if (sel < 60)
                cmd = CMD_WRITE;
            else if (sel < 75)
                cmd = CMD_TICK;
            else if (sel < 87)
                cmd = CMD_RECEIVE;
            else if (sel < 95)
                cmd = CMD_IACK;
            else
                cmd = 3'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
            send_word(cmd, 3'($urandom_range(7)), 8'($urandom_range(255)),
                      4'($urandom_range(15)));
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        rbr_q = '0;
        ier_q = '0;
        iir_q = IIR_RESET;
        fcr_q = '0;
        lcr_q = '0;
        mcr_q = '0;
        lsr_q = LSR_RESET;
        msr_q = '0;
        scr_q = '0;
        dll_q = '0;
        dlm_q = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_divisor_latch();
        test_loopback();
        test_interrupts();
        test_random_traffic(500, 1'b0);
        test_random_traffic(400, 1'b1);
        test_random_traffic(500, 1'b0);
        in_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("words: %0d reads, %0d writes, %0d ticks, %0d receives, %0d acks",
                 words_by_cmd[CMD_READ], words_by_cmd[CMD_WRITE], words_by_cmd[CMD_TICK],
                 words_by_cmd[CMD_RECEIVE], words_by_cmd[CMD_IACK]);
        $display("%0d results checked, %0d with irq pending, %0d transmits, %0d mismatches",
                 results_checked, irq_results, tx_results, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/u8250_pkg.sv
hdl/u8250_in_stage.sv
hdl/u8250_regfile.sv
hdl/u8250_out_stage.sv
hdl/uart_8250_register_model.sv
hdl/u8250_checker.sv
test/testbench.sv
